// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the byte stuffer.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BSRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsrt assertion failed");
`define BSRT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bsrt assertion failed");
`else
`define BSRT_ASSERT(lbl, clk, rst_n, prop)
`define BSRT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/bsrt_pkg.sv -----
// Byte stuffer package: config register codes, rule word layout, queue types.
// No dependencies.
`default_nettype none

package bsrt_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RULE_W     = 59;
  localparam int unsigned CFG_DATA_W = RULE_W;
  localparam int unsigned COUNT_W    = 3;

  // rule word layout
  localparam int unsigned MATCH_LSB  = 0;
  localparam int unsigned OUT_LSB    = 8;
  localparam int unsigned LEN_LSB    = 40;
  localparam int unsigned LEN_RAW_W  = 3;
  localparam int unsigned LEFT_LSB   = 43;
  localparam int unsigned RIGHT_LSB  = 51;
  localparam int unsigned GUARD_W    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_ZERO  = 3'd1;

  // request queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bsrt_front.sv -----
// Front end: rule registers and first-match classification of each byte.
// Depends on bsrt_pkg.
`default_nettype none

module bsrt_front #(
  parameter int unsigned MAX_RULES = 4,
  parameter int unsigned MAX_OUT   = 4,
  parameter int unsigned MAX_FRAME = 4096
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [bsrt_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [bsrt_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic                                    push_i,
  input  wire logic [bsrt_pkg::BYTE_W-1:0]             data_byte_i,
  input  wire logic [$clog2(MAX_FRAME)-1:0]            frame_position_i,
  input  wire logic [$clog2(MAX_FRAME+1)-1:0]          bytes_to_end_i,
  input  wire bsrt_pkg::qstat_t                        qstat_i,
  output logic                                         q_wr_o,
  output logic [$clog2(MAX_OUT+1)+MAX_OUT*bsrt_pkg::BYTE_W-1:0] q_data_o
);

  localparam int unsigned END_W  = $clog2(MAX_FRAME+1);
  localparam int unsigned CMP_W  = END_W + bsrt_pkg::GUARD_W;
  localparam int unsigned LEN_W  = $clog2(MAX_OUT+1);
  localparam int unsigned SEQ_W  = MAX_OUT * bsrt_pkg::BYTE_W;
  localparam int unsigned RIDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [bsrt_pkg::CFG_IDX_W:0] RULE_END =
    (bsrt_pkg::CFG_IDX_W+1)'(int'(bsrt_pkg::REG_RULE_ZERO) + MAX_RULES);

  logic [bsrt_pkg::COUNT_W-1:0]                   count_q;
  logic [MAX_RULES-1:0][bsrt_pkg::RULE_W-1:0]     rule_q;
  logic [bsrt_pkg::COUNT_W-1:0]                   active;
  logic [MAX_RULES-1:0]                           hit;
  logic [RIDX_W-1:0]                              wr_ridx;
  logic                                           rule_sel;
  logic [LEN_W-1:0]                               ent_len;
  logic [SEQ_W-1:0]                               ent_bytes;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [bsrt_pkg::LEN_RAW_W-1:0] raw);
    return (raw > bsrt_pkg::LEN_RAW_W'(MAX_OUT)) ? LEN_W'(MAX_OUT) : LEN_W'(raw);
  endfunction

  assign wr_ridx  = RIDX_W'(cfg_idx_i - bsrt_pkg::REG_RULE_ZERO);
  assign rule_sel = (cfg_idx_i >= bsrt_pkg::REG_RULE_ZERO) && ({1'b0, cfg_idx_i} < RULE_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rule_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bsrt_pkg::REG_RULE_COUNT) begin
        count_q <= cfg_data_i[bsrt_pkg::COUNT_W-1:0];
      end else if (rule_sel) begin
        rule_q[wr_ridx] <= cfg_data_i;
      end
    end
  end

  assign active = (count_q > bsrt_pkg::COUNT_W'(MAX_RULES)) ?
                  bsrt_pkg::COUNT_W'(MAX_RULES) : count_q;

  for (genvar r = 0; r < MAX_RULES; r++) begin : g_rule
    assign hit[r] = (bsrt_pkg::COUNT_W'(r) < active)
        && (rule_q[r][bsrt_pkg::MATCH_LSB +: bsrt_pkg::BYTE_W] == data_byte_i)
        && (CMP_W'(frame_position_i) >= CMP_W'(rule_q[r][bsrt_pkg::LEFT_LSB +: bsrt_pkg::GUARD_W]))
        && (CMP_W'(bytes_to_end_i) > CMP_W'(rule_q[r][bsrt_pkg::RIGHT_LSB +: bsrt_pkg::GUARD_W]));
  end

  // lowest-numbered hit wins
  always_comb begin
    ent_len   = LEN_W'(1);
    ent_bytes = SEQ_W'(data_byte_i);
    for (int r = MAX_RULES - 1; r >= 0; r--) begin
      if (hit[r]) begin
        ent_len   = clamp_len(rule_q[r][bsrt_pkg::LEN_LSB +: bsrt_pkg::LEN_RAW_W]);
        ent_bytes = rule_q[r][bsrt_pkg::OUT_LSB +: SEQ_W];
      end
    end
  end

  // zero-length escapes drop the byte
  assign q_wr_o   = push_i && !qstat_i.full && (ent_len != '0);
  assign q_data_o = {ent_len, ent_bytes};

endmodule

`default_nettype wire

// ----- hw/rtl/bsrt_queue.sv -----
// Two-entry request queue between the classifier and the emitter.
// Depends on bsrt_pkg.
`default_nettype none

module bsrt_queue #(
  parameter int unsigned WIDTH = 35
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output bsrt_pkg::qstat_t      stat_o
);

  logic [WIDTH-1:0]                 mem_q [bsrt_pkg::QDEPTH];
  logic [bsrt_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bsrt_pkg::QCNT_W-1:0]      cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == bsrt_pkg::QCNT_W'(bsrt_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/bsrt_back.sv -----
// Back end: walks the head request into the output register, one byte per cycle while pop allows.
// Depends on bsrt_pkg.
`default_nettype none

module bsrt_back #(
  parameter int unsigned MAX_OUT = 4
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire bsrt_pkg::qstat_t                        qstat_i,
  input  wire logic [$clog2(MAX_OUT+1)+MAX_OUT*bsrt_pkg::BYTE_W-1:0] q_data_i,
  output logic                                         q_rd_o,
  input  wire logic                                    pop,
  output logic                                         empty,
  output logic [bsrt_pkg::BYTE_W-1:0]                  out_byte_o,
  output logic                                         last_of_run_o
);

  localparam int unsigned LEN_W   = $clog2(MAX_OUT+1);
  localparam int unsigned SEQ_W   = MAX_OUT * bsrt_pkg::BYTE_W;
  localparam int unsigned ENTRY_W = LEN_W + SEQ_W;
  localparam int unsigned IDX_W   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int unsigned CNT_W   = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        valid_q;
  logic [bsrt_pkg::BYTE_W-1:0] byte_q;
  logic                        last_q;
  logic [LEN_W-1:0]            head_len;
  logic [SEQ_W-1:0]            head_bytes;
  logic [bsrt_pkg::BYTE_W-1:0] cur_byte;
  logic                        cur_last;
  logic                        take;

  assign head_len   = q_data_i[ENTRY_W-1 -: LEN_W];
  assign head_bytes = q_data_i[SEQ_W-1:0];
  assign cur_byte   = head_bytes[idx_q*bsrt_pkg::BYTE_W +: bsrt_pkg::BYTE_W];
  assign cur_last   = (CNT_W'(idx_q) + CNT_W'(1)) == CNT_W'(head_len);

  assign take   = (!valid_q || pop) && !qstat_i.empty;
  assign q_rd_o = take && cur_last;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = cur_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= take || (valid_q && !pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= cur_byte;
      last_q <= cur_last;
    end
  end

  assign empty         = !valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/byte_stuffer_rule_table_unit.sv -----
// The input request is registered in the request queue, then its first result byte in the output register.
// Throughput: one input byte per cycle while full is low; a request expanding to n escape bytes holds the
// emitter until all n bytes are taken, and full rises once both entries of the two-entry request queue are occupied.
// Reset clears the rule count and all rule words to zero and empties the queue.
// Depends on bsrt_pkg, bsrt_front, bsrt_queue, bsrt_back, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module byte_stuffer_rule_table_unit #(
  parameter int unsigned MAX_RULES = 4,
  parameter int unsigned MAX_OUT   = 4,
  parameter int unsigned MAX_FRAME = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bsrt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bsrt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [bsrt_pkg::BYTE_W-1:0]       data_byte_i,
  input  wire logic [$clog2(MAX_FRAME)-1:0]      frame_position_i,
  input  wire logic [$clog2(MAX_FRAME+1)-1:0]    bytes_to_end_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [bsrt_pkg::BYTE_W-1:0]            out_byte_o,
  output logic                                   last_of_run_o
);

  localparam int unsigned LEN_W   = $clog2(MAX_OUT+1);
  localparam int unsigned ENTRY_W = LEN_W + MAX_OUT * bsrt_pkg::BYTE_W;

  bsrt_pkg::qstat_t    q_stat;
  logic                q_wr;
  logic                q_rd;
  logic [ENTRY_W-1:0]  q_wdata;
  logic [ENTRY_W-1:0]  q_rdata;

  bsrt_front #(
    .MAX_RULES (MAX_RULES),
    .MAX_OUT   (MAX_OUT),
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push),
    .data_byte_i      (data_byte_i),
    .frame_position_i (frame_position_i),
    .bytes_to_end_i   (bytes_to_end_i),
    .qstat_i          (q_stat),
    .q_wr_o           (q_wr),
    .q_data_o         (q_wdata)
  );

  bsrt_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .stat_o    (q_stat)
  );

  bsrt_back #(
    .MAX_OUT (MAX_OUT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (q_stat),
    .q_data_i      (q_rdata),
    .q_rd_o        (q_rd),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  assign full = q_stat.full;

  `BSRT_ASSERT_ALWAYS(a_no_overflow, clk_i, q_wr |-> !q_stat.full)
  `BSRT_ASSERT(a_no_empty_request, clk_i, rst_ni, q_wr |-> (q_wdata[ENTRY_W-1 -: LEN_W] != '0))
  `BSRT_ASSERT(a_back_drains, clk_i, rst_ni, (empty && !q_stat.empty) |=> !empty)
  `BSRT_ASSERT(a_rd_only_nonempty, clk_i, rst_ni, q_rd |-> !q_stat.empty)

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for byte_stuffer_rule_table_unit: drives framed byte requests
// with random gaps and back-pressure, and checks every emitted byte against a predictor.
// Depends on bsrt_pkg and the byte stuffer RTL.
module testbench;

  localparam int RULES_MAX    = 4;
  localparam int ESC_MAX      = 4;
  localparam int FRAME_MAX    = 4096;
  localparam int POS_W        = $clog2(FRAME_MAX);
  localparam int END_W        = $clog2(FRAME_MAX + 1);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 80;
  localparam logic [bsrt_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    bsrt_pkg::REG_RULE_ZERO + 3'd4;

  typedef struct packed {
    logic [bsrt_pkg::BYTE_W-1:0] value;
    logic                        last;
  } emitted_t;

  class stuffing_board;
    logic [bsrt_pkg::COUNT_W-1:0] rule_count;
    logic [bsrt_pkg::RULE_W-1:0]  rules[RULES_MAX];
    emitted_t                     pending_bytes[$];
    int                           checked;
    int                           errors;

    function new();
      rule_count = '0;
      foreach (rules[i]) rules[i] = '0;
      checked = 0;
      errors  = 0;
    endfunction

    function void reg_write(logic [bsrt_pkg::CFG_IDX_W-1:0] idx,
                            logic [bsrt_pkg::CFG_DATA_W-1:0] data);
      if (idx == bsrt_pkg::REG_RULE_COUNT)
        rule_count = data[bsrt_pkg::COUNT_W-1:0];
      else if (idx >= bsrt_pkg::REG_RULE_ZERO && idx < REG_FIRST_UNUSED)
        rules[idx - bsrt_pkg::REG_RULE_ZERO] = data[bsrt_pkg::RULE_W-1:0];
    endfunction

    // expand one request into its emitted bytes
    function void note_request(logic [bsrt_pkg::BYTE_W-1:0] value, logic [POS_W-1:0] pos,
                               logic [END_W-1:0] to_end);
      int active;
      int len;
      bit hit;
      logic [bsrt_pkg::RULE_W-1:0] w;
      emitted_t e;
      active = (int'(rule_count) > RULES_MAX) ? RULES_MAX : int'(rule_count);
      hit = 1'b0;
      for (int r = 0; r < active; r++) begin
        w = rules[r];
        if (!hit && value == w[bsrt_pkg::MATCH_LSB +: bsrt_pkg::BYTE_W]
            && pos >= w[bsrt_pkg::LEFT_LSB +: bsrt_pkg::GUARD_W]
            && to_end > w[bsrt_pkg::RIGHT_LSB +: bsrt_pkg::GUARD_W]) begin
          hit = 1'b1;
          len = int'(w[bsrt_pkg::LEN_LSB +: bsrt_pkg::LEN_RAW_W]);
          if (len > ESC_MAX) len = ESC_MAX;
          for (int k = 0; k < len; k++) begin
            e.value = w[bsrt_pkg::OUT_LSB + bsrt_pkg::BYTE_W * k +: bsrt_pkg::BYTE_W];
            e.last  = (k == len - 1);
            pending_bytes.push_back(e);
          end
        end
      end
      if (!hit) begin
        e.value = value;
        e.last  = 1'b1;
        pending_bytes.push_back(e);
      end
    endfunction

    function void check_emitted(logic [bsrt_pkg::BYTE_W-1:0] value, logic last);
      emitted_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output: out_byte %h last_of_run %b", value, last);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      checked++;
      if (value !== want.value) begin
        $error("out_byte: expected %h, got %h", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [bsrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [bsrt_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            push;
  logic                            full;
  logic [bsrt_pkg::BYTE_W-1:0]     data_byte_i;
  logic [POS_W-1:0]                frame_position_i;
  logic [END_W-1:0]                bytes_to_end_i;
  logic                            empty;
  logic                            pop;
  logic [bsrt_pkg::BYTE_W-1:0]     out_byte_o;
  logic                            last_of_run_o;

  stuffing_board sb;
  int  cycles;
  int  sent_items;
  int  settings_used;
  bit  hold_req;
  bit  rx_steady;
  int  hold_left;

  byte_stuffer_rule_table_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .frame_position_i (frame_position_i),
    .bytes_to_end_i   (bytes_to_end_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_ni) begin
      if (pop && !empty) sb.check_emitted(out_byte_o, last_of_run_o);
      if (push && !full) sb.note_request(data_byte_i, frame_position_i, bytes_to_end_i);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_guard();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(0, 4));
    if (r < 9) return 8'($urandom_range(0, 40));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [bsrt_pkg::RULE_W-1:0] make_rule();
    logic [7:0]  hit_value;
    logic [7:0]  left;
    logic [7:0]  right;
    logic [2:0]  len;
    logic [31:0] esc;
    int          r;
    hit_value = 8'($urandom_range(0, 255));
    esc       = $urandom;
    left      = pick_guard();
    right     = pick_guard();
    r = $urandom_range(0, 19);
    if (r == 0)      len = 3'd0;
    else if (r == 1) len = 3'($urandom_range(5, 7));
    else             len = 3'($urandom_range(1, 4));
    return {right, left, len, esc, hit_value};
  endfunction

  // the next request is entered at a falling edge, the task returns at one
  task automatic send_byte(input logic [bsrt_pkg::BYTE_W-1:0] value,
                           input logic [POS_W-1:0] pos,
                           input logic [END_W-1:0] to_end, input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push             <= 1'b1;
    data_byte_i      <= value;
    frame_position_i <= pos;
    bytes_to_end_i   <= to_end;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    sent_items++;
  endtask

  task automatic write_reg(input logic [bsrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsrt_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sb.reg_write(idx, data);
  endtask

  task automatic wait_results();
    push <= 1'b0;
    do @(negedge clk_i); while (sb.pending_bytes.size() != 0);
  endtask

  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_rules(input logic [bsrt_pkg::COUNT_W-1:0] count, input bit raw_words);
    logic [63:0] w;
    for (int i = 0; i < RULES_MAX; i++) begin
      w = {$urandom, $urandom};
      write_reg(bsrt_pkg::CFG_IDX_W'(int'(bsrt_pkg::REG_RULE_ZERO) + i),
                raw_words ? w[bsrt_pkg::RULE_W-1:0] : make_rule());
    end
    write_reg(bsrt_pkg::REG_RULE_COUNT, bsrt_pkg::CFG_DATA_W'(count));
    settings_used++;
  endtask

  function automatic logic [bsrt_pkg::BYTE_W-1:0] pick_data();
    int active;
    active = (int'(sb.rule_count) > RULES_MAX) ? RULES_MAX : int'(sb.rule_count);
    if (active > 0 && $urandom_range(0, 99) < 55)
      return sb.rules[$urandom_range(0, active - 1)][bsrt_pkg::MATCH_LSB +: bsrt_pkg::BYTE_W];
    return bsrt_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // mostly runs of consecutive bytes from one frame, some unrelated requests
  task automatic run_random(input int count, input bit steady);
    int left_to_send;
    int frame_len;
    int pos;
    int run_len;
    int r;
    left_to_send = count;
    while (left_to_send > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        send_byte(bsrt_pkg::BYTE_W'($urandom_range(0, 255)),
                  POS_W'($urandom_range(0, FRAME_MAX - 1)),
                  END_W'($urandom_range(0, (1 << END_W) - 1)), steady);
        left_to_send--;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7)      frame_len = $urandom_range(1, 24);
        else if (r < 9) frame_len = $urandom_range(25, 300);
        else            frame_len = $urandom_range(301, FRAME_MAX);
        pos = $urandom_range(0, frame_len - 1);
        run_len = $urandom_range(1, 16);
        if (run_len > frame_len - pos) run_len = frame_len - pos;
        if (run_len > left_to_send) run_len = left_to_send;
        for (int k = 0; k < run_len; k++) begin
          send_byte(pick_data(), POS_W'(pos + k), END_W'(frame_len - pos - k), steady);
        end
        left_to_send -= run_len;
      end
    end
  endtask

  initial begin : receiver
    int stall_left;
    int r;
    pop = 1'b0;
    stall_left = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_steady) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
        end
      end
    end
  end

  initial begin : stimulus
    sb = new();
    cycles = 0;
    sent_items = 0;
    settings_used = 1;
    hold_req = 1'b0;
    rx_steady = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    push = 1'b0;
    data_byte_i = '0;
    frame_position_i = '0;
    bytes_to_end_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset state: no rules, bytes pass through
    send_byte(8'h7E, 12'd0, 13'd1, 1'b0);
    send_byte(8'hFF, 12'hFFF, 13'd4096, 1'b0);
    settle();

    write_reg(bsrt_pkg::REG_RULE_ZERO,
              {8'd1, 8'd1, 3'd2, 32'h0000_5E7D, 8'h7E});
    write_reg(bsrt_pkg::REG_RULE_ZERO + 3'd1,
              {8'd0, 8'd0, 3'd2, 32'h0000_5D7D, 8'h7D});
    write_reg(bsrt_pkg::REG_RULE_ZERO + 3'd2,
              {8'd0, 8'd0, 3'd0, 32'hA5A5_A5A5, 8'h00});
    write_reg(bsrt_pkg::REG_RULE_ZERO + 3'd3,
              {8'd0, 8'd0, 3'd7, 32'h4433_2211, 8'hFF});
    write_reg(bsrt_pkg::REG_RULE_COUNT, bsrt_pkg::CFG_DATA_W'(3'd7));
    send_byte(8'h7E, 12'd0, 13'd10, 1'b0);    // left guard blocks
    send_byte(8'h7E, 12'd1, 13'd10, 1'b0);
    send_byte(8'h7E, 12'd5, 13'd1, 1'b0);     // right guard blocks
    send_byte(8'h7E, 12'd5, 13'd2, 1'b0);
    send_byte(8'h7E, 12'd5, 13'd0, 1'b0);     // zero bytes to end
    send_byte(8'h7D, 12'd3, 13'd3, 1'b0);
    send_byte(8'h00, 12'd0, 13'd1, 1'b0);     // dropped
    send_byte(8'h00, 12'hFFF, 13'd0, 1'b0);
    send_byte(8'hFF, 12'hFFF, 13'h1FFF, 1'b0); // length clamped
    send_byte(8'h55, 12'd2048, 13'd4096, 1'b0);
    send_byte(8'h00, 12'd7, 13'd9, 1'b1);
    send_byte(8'h00, 12'd8, 13'd8, 1'b1);
    send_byte(8'hFF, 12'd9, 13'd7, 1'b1);
    settle();

    // writes to unknown indexes must not disturb the rules
    for (int i = 0; i < 3; i++) begin
      write_reg(bsrt_pkg::CFG_IDX_W'(int'(REG_FIRST_UNUSED) + i), '1);
    end
    send_byte(8'h7E, 12'd1, 13'd10, 1'b0);
    settle();

    write_reg(bsrt_pkg::REG_RULE_COUNT, bsrt_pkg::CFG_DATA_W'(3'd1));
    send_byte(8'h7D, 12'd3, 13'd3, 1'b0);
    send_byte(8'hFF, 12'd3, 13'd3, 1'b0);
    settle();

    write_reg(bsrt_pkg::REG_RULE_ZERO + 3'd3,
              {8'd0, 8'd0, 3'd4, 32'hDDCC_BBAA, 8'hFF});
    write_reg(bsrt_pkg::REG_RULE_COUNT, bsrt_pkg::CFG_DATA_W'(3'd4));
    send_byte(8'hFF, 12'd0, 13'd1, 1'b0);
    send_byte(8'h00, 12'd1, 13'd1, 1'b0);
    settle();
    settings_used += 3;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_rules(3'd0, 1'b0);
        1: set_rules(3'd1, 1'b0);
        2: set_rules(3'd4, 1'b0);
        3: set_rules(3'd7, 1'b0);
        4: begin
          write_reg(bsrt_pkg::REG_RULE_ZERO, '1);
          write_reg(bsrt_pkg::REG_RULE_ZERO + 3'd1, '0);
          write_reg(bsrt_pkg::REG_RULE_COUNT, bsrt_pkg::CFG_DATA_W'(3'd2));
          settings_used++;
        end
        5: set_rules(bsrt_pkg::COUNT_W'($urandom_range(0, 7)), 1'b1);
        6: set_rules(3'd3, 1'b0);
        default: set_rules(3'd4, 1'b0);
      endcase
      rx_steady = (ph == 7);
      if (ph == 2) begin
        run_random(12, 1'b0);
        hold_req = 1'b1;      // output held off while requests keep coming
        run_random(44, 1'b0);
      end else if (ph == 3) begin
        run_random(25, 1'b0);
        wait_results();
        run_random(31, 1'b0);
      end else begin
        run_random(56, ph == 7);
      end
      settle();
    end

    $display("Covered %0d input bytes under %0d rule settings, %0d output bytes checked.",
             sent_items, settings_used, sb.checked);
    $display("Included guard edges, drops, clamped counts and lengths, and a full stall.");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
